[rtl/i2cm_pkg.sv]
package i2cm_pkg;

	localparam int unsigned HOLD_BITS_DEF = 16;
	localparam int unsigned HALF_W = 16;
	localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd360;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_SACK  = 3'd5,
		CMD_RACK  = 3'd6
	} i2cm_cmd_t;

	typedef enum logic {
		PIN_SCL = 1'b0,
		PIN_SDA = 1'b1
	} i2cm_pin_t;

	typedef struct packed {
		i2cm_pin_t pin;
		logic      lvl;
	} i2cm_act_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
		logic       cmd_refused;
	} i2cm_res_t;

endpackage

[rtl/i2cm_ifs.sv]
interface i2cm_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] data_byte;
	logic       ack_level;
	logic       sda_in;

	modport source (output valid, output opcode, output data_byte, output ack_level,
		output sda_in, input ready);
	modport sink (input valid, input opcode, input data_byte, input ack_level,
		input sda_in, output ready);
endinterface

interface i2cm_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;
	logic       cmd_refused;

	modport source (output valid, output scl_out, output sda_out, output busy_res,
		output done_res, output rx_byte, output ack_seen, output cmd_refused, input ready);
	modport sink (input valid, input scl_out, input sda_out, input busy_res,
		input done_res, input rx_byte, input ack_seen, input cmd_refused, output ready);
endinterface

interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] half_period_ticks;

	modport source (output valid, output half_period_ticks, input ready);
	modport sink (input valid, input half_period_ticks, output ready);
endinterface

[rtl/i2cm_cfg.sv]
module i2cm_cfg #(
	parameter int unsigned HOLD_BITS = i2cm_pkg::HOLD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	i2cm_cfg_if.sink             cfg,
	output logic [HOLD_BITS-1:0] hold_load
);

	logic [i2cm_pkg::HALF_W-1:0] half_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= i2cm_pkg::HALF_PERIOD_RST;
		end else if (cfg.valid) begin
			half_q <= cfg.half_period_ticks;
		end
	end

	// mask or widen to the hold counter width
	generate
		if (HOLD_BITS > i2cm_pkg::HALF_W) begin : g_wide
			assign hold_load = {{(HOLD_BITS - i2cm_pkg::HALF_W){1'b0}}, half_q};
		end else if (HOLD_BITS == i2cm_pkg::HALF_W) begin : g_same
			assign hold_load = half_q;
		end else begin : g_narrow
			assign hold_load = half_q[HOLD_BITS-1:0];
		end
	endgenerate

endmodule

[rtl/i2cm_engine.sv]
module i2cm_engine #(
	parameter int unsigned HOLD_BITS = i2cm_pkg::HOLD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [2:0]           opcode,
	input  logic [7:0]           data_byte,
	input  logic                 ack_level,
	input  logic                 sda_in,
	input  logic [HOLD_BITS-1:0] hold_load,
	output i2cm_pkg::i2cm_res_t  res
);

	localparam logic [HOLD_BITS-1:0] HOLD_ONE = {{(HOLD_BITS-1){1'b0}}, 1'b1};

	function automatic logic [4:0] step_count(input i2cm_pkg::i2cm_cmd_t cmd);
		logic [4:0] n;
		unique case (cmd)
			i2cm_pkg::CMD_START: n = 5'd4;
			i2cm_pkg::CMD_STOP:  n = 5'd3;
			i2cm_pkg::CMD_WRITE: n = 5'd24;
			i2cm_pkg::CMD_READ:  n = 5'd17;
			i2cm_pkg::CMD_SACK:  n = 5'd3;
			i2cm_pkg::CMD_RACK:  n = 5'd3;
			default:             n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic i2cm_pkg::i2cm_act_t step_action(input i2cm_pkg::i2cm_cmd_t cmd,
		input logic [4:0] idx, input logic [1:0] phase, input logic [2:0] third,
		input logic [7:0] tx);
		i2cm_pkg::i2cm_act_t a;
		a.pin = i2cm_pkg::PIN_SCL;
		a.lvl = 1'b0;
		unique case (cmd)
			i2cm_pkg::CMD_START: begin
				a.pin = idx[0] ? i2cm_pkg::PIN_SCL : i2cm_pkg::PIN_SDA;
				a.lvl = ~idx[1];
			end
			i2cm_pkg::CMD_STOP: begin
				if (idx == 5'd0) begin
					a.pin = i2cm_pkg::PIN_SDA;
					a.lvl = 1'b0;
				end else if (idx == 5'd1) begin
					a.lvl = 1'b1;
				end else if (idx == 5'd2) begin
					a.pin = i2cm_pkg::PIN_SDA;
					a.lvl = 1'b1;
				end
			end
			i2cm_pkg::CMD_WRITE: begin
				if (phase == 2'd0) begin
					a.pin = i2cm_pkg::PIN_SDA;
					a.lvl = tx[3'd7 - third];
				end else begin
					a.lvl = (phase == 2'd1);
				end
			end
			i2cm_pkg::CMD_READ: begin
				if (idx == 5'd0) begin
					a.pin = i2cm_pkg::PIN_SDA;
					a.lvl = 1'b1;
				end else begin
					a.lvl = idx[0];
				end
			end
			i2cm_pkg::CMD_SACK, i2cm_pkg::CMD_RACK: begin
				if (idx == 5'd0) begin
					a.pin = i2cm_pkg::PIN_SDA;
					a.lvl = (cmd == i2cm_pkg::CMD_SACK) ? tx[0] : 1'b1;
				end else begin
					a.lvl = (idx == 5'd1);
				end
			end
			default: begin
				a.lvl = 1'b0;
			end
		endcase
		return a;
	endfunction

	i2cm_pkg::i2cm_cmd_t  active_q, active_d;
	logic [4:0]           step_q, step_d;
	logic [1:0]           phase_q, phase_d;
	logic [2:0]           third_q, third_d;
	logic [HOLD_BITS-1:0] hold_q, hold_d;
	logic                 scl_q, scl_d;
	logic                 sda_q, sda_d;
	logic [7:0]           shift_q, shift_d;
	logic                 ack_q, ack_d;
	logic [7:0]           tx_q, tx_d;
	logic                 is_cmd;
	logic                 done;
	logic                 refused;
	logic                 apply;
	i2cm_pkg::i2cm_act_t  act;
	logic [4:0]           step_inc;
	logic [1:0]           phase_inc;
	logic [2:0]           third_inc;

	assign is_cmd = (opcode >= 3'(i2cm_pkg::CMD_START)) && (opcode <= 3'(i2cm_pkg::CMD_RACK));
	assign step_inc = step_q + 5'd1;
	assign phase_inc = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
	assign third_inc = (phase_q == 2'd2) ? third_q + 3'd1 : third_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= i2cm_pkg::CMD_IDLE;
			step_q   <= '0;
			phase_q  <= '0;
			third_q  <= '0;
			hold_q   <= '0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			shift_q  <= '0;
			ack_q    <= 1'b0;
			tx_q     <= '0;
		end else if (accept) begin
			active_q <= active_d;
			step_q   <= step_d;
			phase_q  <= phase_d;
			third_q  <= third_d;
			hold_q   <= hold_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
			shift_q  <= shift_d;
			ack_q    <= ack_d;
			tx_q     <= tx_d;
		end
	end

	always_comb begin
		active_d = active_q;
		step_d   = step_q;
		phase_d  = phase_q;
		third_d  = third_q;
		hold_d   = hold_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		shift_d  = shift_q;
		ack_d    = ack_q;
		tx_d     = tx_q;
		done     = 1'b0;
		refused  = 1'b0;
		apply    = 1'b0;

		if (active_q != i2cm_pkg::CMD_IDLE) begin
			refused = is_cmd;
			if (hold_q > HOLD_ONE) begin
				hold_d = hold_q - HOLD_ONE;
			end else begin
				// end of the hold: sample at the end of scl high
				if (active_q == i2cm_pkg::CMD_READ && step_q[0] && sda_in) begin
					shift_d[3'd7 - step_q[3:1]] = 1'b1;
				end
				if (active_q == i2cm_pkg::CMD_RACK && step_q == 5'd1) begin
					ack_d = sda_in;
				end
				if (step_inc >= step_count(active_q)) begin
					active_d = i2cm_pkg::CMD_IDLE;
					step_d   = '0;
					phase_d  = '0;
					third_d  = '0;
					hold_d   = '0;
					done     = 1'b1;
				end else begin
					step_d  = step_inc;
					phase_d = phase_inc;
					third_d = third_inc;
					apply   = 1'b1;
				end
			end
		end else if (is_cmd) begin
			active_d = i2cm_pkg::i2cm_cmd_t'(opcode);
			step_d   = '0;
			phase_d  = '0;
			third_d  = '0;
			apply    = 1'b1;
			if (active_d == i2cm_pkg::CMD_WRITE) begin
				tx_d = data_byte;
			end
			if (active_d == i2cm_pkg::CMD_SACK) begin
				tx_d = {7'd0, ack_level};
			end
			if (active_d == i2cm_pkg::CMD_READ) begin
				shift_d = '0;
			end
		end

		act = step_action(active_d, step_d, phase_d, third_d, tx_d);
		if (apply) begin
			hold_d = hold_load;
			if (act.pin == i2cm_pkg::PIN_SCL) begin
				scl_d = act.lvl;
			end else begin
				sda_d = act.lvl;
			end
		end

		res.scl_out     = scl_d;
		res.sda_out     = sda_d;
		res.busy_res    = (active_d != i2cm_pkg::CMD_IDLE);
		res.done_res    = done;
		res.rx_byte     = shift_d;
		res.ack_seen    = ack_d;
		res.cmd_refused = refused;
	end

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && active_q == i2cm_pkg::CMD_IDLE && is_cmd |=> active_q != i2cm_pkg::CMD_IDLE)
		else $error("command start did not make the engine busy");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q != i2cm_pkg::CMD_IDLE |-> step_q < step_count(active_q))
		else $error("step index beyond command length");
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(active_q) && $stable(hold_q) && $stable(step_q))
		else $error("engine state moved without an item");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q == i2cm_pkg::CMD_WRITE |-> phase_q != 2'd3)
		else $error("write phase out of range");
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		active_q == i2cm_pkg::CMD_IDLE |-> step_q == 5'd0 && hold_q == '0)
		else $error("idle engine with live step or hold");
`endif

endmodule

[rtl/i2cm_out_reg.sv]
module i2cm_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  i2cm_pkg::i2cm_res_t res,
	output logic                up_ready,
	i2cm_rsp_if.source          rsp
);

	logic                valid_q;
	i2cm_pkg::i2cm_res_t res_q;

	assign up_ready = ~valid_q | rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.scl_out     = res_q.scl_out;
	assign rsp.sda_out     = res_q.sda_out;
	assign rsp.busy_res    = res_q.busy_res;
	assign rsp.done_res    = res_q.done_res;
	assign rsp.rx_byte     = res_q.rx_byte;
	assign rsp.ack_seen    = res_q.ack_seen;
	assign rsp.cmd_refused = res_q.cmd_refused;

endmodule

[rtl/i2c_master_bit_engine_core.sv]
// a result item is valid in the cycle after its input item is accepted
// throughput: one item per cycle while the result slot can take it, set by the state update in the engine
// the output register passes ready through, so an item is taken whenever the result
// slot is empty or being drained in the same cycle
// reset: scl and sda released, engine idle, half period back to 360 ticks
module i2c_master_bit_engine_core #(
	parameter int unsigned HOLD_BITS = i2cm_pkg::HOLD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_req_if.sink   req,
	i2cm_rsp_if.source rsp,
	i2cm_cfg_if.sink   cfg
);

	logic                 up_ready;
	logic                 accept;
	logic [HOLD_BITS-1:0] hold_load;
	i2cm_pkg::i2cm_res_t  res;

	assign req.ready = up_ready;
	assign accept = req.valid & up_ready;

	i2cm_cfg #(
		.HOLD_BITS (HOLD_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.hold_load (hold_load)
	);

	i2cm_engine #(
		.HOLD_BITS (HOLD_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (req.opcode),
		.data_byte (req.data_byte),
		.ack_level (req.ack_level),
		.sda_in    (req.sda_in),
		.hold_load (hold_load),
		.res       (res)
	);

	i2cm_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.up_ready (up_ready),
		.rsp      (rsp)
	);

endmodule

[tb/tb_top.sv]
module tb_top;

	localparam logic [2:0] OP_SPARE = 3'd7;
	localparam int unsigned STALL_LIMIT = 4000;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
		logic       ack_level;
		logic       sda_in;
	} tick_item_t;

	logic clk = 1'b0;
	logic arst_n;

	i2cm_req_if req();
	i2cm_rsp_if rsp();
	i2cm_cfg_if cfg();

	i2c_master_bit_engine_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// engine state as predicted
	logic [15:0]         hp_q;
	logic                scl_q;
	logic                sda_q;
	i2cm_pkg::i2cm_cmd_t cmd_q;
	logic [4:0]          step_q;
	logic [15:0]         hold_q;
	logic [7:0]          shift_q;
	logic [7:0]          tx_q;
	logic                ack_q;

	tick_item_t          pending_ticks[$];
	i2cm_pkg::i2cm_res_t expected_bus[$];
	tick_item_t          on_bus;
	i2cm_pkg::i2cm_res_t predicted;
	i2cm_pkg::i2cm_res_t want;
	int unsigned         pushed;
	int unsigned         err_count;
	int unsigned         result_count;
	int unsigned         quiet_cycles;
	int unsigned         tx_idle_pct;
	int unsigned         rx_stall_pct;

	function automatic int unsigned cmd_steps(input logic [2:0] op);
		case (op)
			i2cm_pkg::CMD_START: return 4;
			i2cm_pkg::CMD_STOP:  return 3;
			i2cm_pkg::CMD_WRITE: return 24;
			i2cm_pkg::CMD_READ:  return 17;
			i2cm_pkg::CMD_SACK:  return 3;
			i2cm_pkg::CMD_RACK:  return 3;
			default:             return 0;
		endcase
	endfunction

	function automatic int unsigned hold_ticks();
		return (hp_q == 16'd0) ? 1 : int'(hp_q);
	endfunction

	function automatic i2cm_pkg::i2cm_act_t pin_change(input i2cm_pkg::i2cm_cmd_t c,
		input logic [4:0] idx, input logic [7:0] tx);
		i2cm_pkg::i2cm_act_t a;
		a.pin = i2cm_pkg::PIN_SCL;
		a.lvl = 1'b0;
		case (c)
			i2cm_pkg::CMD_START: begin
				a.pin = idx[0] ? i2cm_pkg::PIN_SCL : i2cm_pkg::PIN_SDA;
				a.lvl = ~idx[1];
			end
			i2cm_pkg::CMD_STOP: begin
				a.pin = (idx == 5'd1) ? i2cm_pkg::PIN_SCL : i2cm_pkg::PIN_SDA;
				a.lvl = (idx != 5'd0);
			end
			i2cm_pkg::CMD_WRITE: begin
				if (idx % 3 == 0) begin
					a.pin = i2cm_pkg::PIN_SDA;
					a.lvl = tx[7 - ((idx / 3) & 7)];
				end else begin
					a.lvl = (idx % 3 == 1);
				end
			end
			i2cm_pkg::CMD_READ: begin
				if (idx == 5'd0) begin
					a.pin = i2cm_pkg::PIN_SDA;
					a.lvl = 1'b1;
				end else begin
					a.lvl = idx[0];
				end
			end
			i2cm_pkg::CMD_SACK, i2cm_pkg::CMD_RACK: begin
				if (idx == 5'd0) begin
					a.pin = i2cm_pkg::PIN_SDA;
					a.lvl = (c == i2cm_pkg::CMD_SACK) ? tx[0] : 1'b1;
				end else begin
					a.lvl = (idx == 5'd1);
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic model_reset();
		scl_q = 1'b1;
		sda_q = 1'b1;
		cmd_q = i2cm_pkg::CMD_IDLE;
		step_q = 5'd0;
		hold_q = 16'd0;
		shift_q = 8'd0;
		tx_q = 8'd0;
		ack_q = 1'b0;
	endtask

	task automatic apply_change();
		i2cm_pkg::i2cm_act_t a;
		a = pin_change(cmd_q, step_q, tx_q);
		if (a.pin == i2cm_pkg::PIN_SCL) scl_q = a.lvl;
		else sda_q = a.lvl;
		hold_q = hp_q;
	endtask

	task automatic engine_tick(input tick_item_t it, output i2cm_pkg::i2cm_res_t r);
		logic is_cmd;
		logic done;
		logic refused;
		is_cmd = (it.opcode >= 3'(i2cm_pkg::CMD_START)) &&
			(it.opcode <= 3'(i2cm_pkg::CMD_RACK));
		done = 1'b0;
		refused = 1'b0;
		if (cmd_q != i2cm_pkg::CMD_IDLE) begin
			refused = is_cmd;
			if (hold_q > 16'd1) begin
				hold_q = hold_q - 16'd1;
			end else begin
				// end of the hold: sample, then move on
				if (cmd_q == i2cm_pkg::CMD_READ && step_q[0] && it.sda_in)
					shift_q[7 - ((step_q - 5'd1) >> 1)] = 1'b1;
				if (cmd_q == i2cm_pkg::CMD_RACK && step_q == 5'd1)
					ack_q = it.sda_in;
				step_q = step_q + 5'd1;
				if (step_q >= cmd_steps(cmd_q)) begin
					cmd_q = i2cm_pkg::CMD_IDLE;
					step_q = 5'd0;
					hold_q = 16'd0;
					done = 1'b1;
				end else begin
					apply_change();
				end
			end
		end else if (is_cmd) begin
			cmd_q = i2cm_pkg::i2cm_cmd_t'(it.opcode);
			step_q = 5'd0;
			if (cmd_q == i2cm_pkg::CMD_WRITE) tx_q = it.data_byte;
			if (cmd_q == i2cm_pkg::CMD_SACK) tx_q = {7'd0, it.ack_level};
			if (cmd_q == i2cm_pkg::CMD_READ) shift_q = 8'd0;
			apply_change();
		end
		r.scl_out = scl_q;
		r.sda_out = sda_q;
		r.busy_res = (cmd_q != i2cm_pkg::CMD_IDLE);
		r.done_res = done;
		r.rx_byte = shift_q;
		r.ack_seen = ack_q;
		r.cmd_refused = refused;
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH result %0d: %s", result_count, what);
		err_count++;
	endtask

	task automatic push_item(input logic [2:0] op, input logic [7:0] db, input logic al,
		input logic si);
		tick_item_t it;
		it.opcode = op;
		it.data_byte = db;
		it.ack_level = al;
		it.sda_in = si;
		pending_ticks.push_back(it);
		pushed++;
	endtask

	function automatic logic [2:0] filler_op();
		return ($urandom_range(11) == 0) ? 3'($urandom_range(7, 1)) : 3'(i2cm_pkg::CMD_IDLE);
	endfunction

	task automatic directed_command(input logic [2:0] op, input logic [7:0] db, input logic al,
		input logic si, input logic [2:0] last_op);
		int unsigned span;
		int unsigned k;
		span = cmd_steps(op) * hold_ticks();
		push_item(op, db, al, si);
		for (k = 1; k <= span; k++)
			push_item((k == span) ? last_op : 3'(i2cm_pkg::CMD_IDLE), 8'd0, 1'b0, si);
	endtask

	task automatic random_sequence();
		logic [2:0] op;
		int unsigned span;
		int unsigned k;
		op = 3'($urandom_range(int'(i2cm_pkg::CMD_RACK), int'(i2cm_pkg::CMD_START)));
		push_item(op, 8'($urandom), 1'($urandom), 1'($urandom));
		span = cmd_steps(op) * hold_ticks();
		// cut short now and then so the next command lands mid-sequence
		if ($urandom_range(7) == 0) span = $urandom_range(span);
		for (k = 0; k < span; k++)
			push_item(filler_op(), 8'($urandom), 1'($urandom), 1'($urandom));
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(4, 1))
				push_item(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic settle();
		while (result_count != pushed) @(posedge clk);
		while (cmd_q != i2cm_pkg::CMD_IDLE) begin
			push_item(3'(i2cm_pkg::CMD_IDLE), 8'd0, 1'b0, 1'b1);
			while (result_count != pushed) @(posedge clk);
		end
	endtask

	task automatic write_hold(input logic [15:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.half_period_ticks <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		hp_q = v;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= 3'(i2cm_pkg::CMD_IDLE);
			req.data_byte <= 8'd0;
			req.ack_level <= 1'b0;
			req.sda_in <= 1'b1;
			model_reset();
		end else begin
			if (req.valid && req.ready) begin
				engine_tick(on_bus, predicted);
				expected_bus.push_back(predicted);
			end
			if (!req.valid || req.ready) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					on_bus = pending_ticks.pop_front();
					req.valid <= 1'b1;
					req.opcode <= on_bus.opcode;
					req.data_byte <= on_bus.data_byte;
					req.ack_level <= on_bus.ack_level;
					req.sda_in <= on_bus.sda_in;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			result_count = 0;
			err_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_bus.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_bus.pop_front();
					if (rsp.scl_out !== want.scl_out)
						report_mismatch($sformatf("scl_out %b, want %b", rsp.scl_out, want.scl_out));
					if (rsp.sda_out !== want.sda_out)
						report_mismatch($sformatf("sda_out %b, want %b", rsp.sda_out, want.sda_out));
					if (rsp.busy_res !== want.busy_res)
						report_mismatch($sformatf("busy_res %b, want %b", rsp.busy_res,
							want.busy_res));
					if (rsp.done_res !== want.done_res)
						report_mismatch($sformatf("done_res %b, want %b", rsp.done_res,
							want.done_res));
					if (rsp.rx_byte !== want.rx_byte)
						report_mismatch($sformatf("rx_byte %h, want %h", rsp.rx_byte, want.rx_byte));
					if (rsp.ack_seen !== want.ack_seen)
						report_mismatch($sformatf("ack_seen %b, want %b", rsp.ack_seen,
							want.ack_seen));
					if (rsp.cmd_refused !== want.cmd_refused)
						report_mismatch($sformatf("cmd_refused %b, want %b", rsp.cmd_refused,
							want.cmd_refused));
				end
				result_count++;
			end
			rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
			(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned ph;
		int unsigned mode;
		int unsigned target;
		cfg.valid = 1'b0;
		cfg.half_period_ticks = 16'd0;
		hp_q = i2cm_pkg::HALF_PERIOD_RST;
		pushed = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// levels from reset
		push_item(OP_SPARE, 8'hFF, 1'b1, 1'b1);
		settle();

		// zero hold acts as one
		write_hold(16'd0);
		push_item(OP_SPARE, 8'h00, 1'b0, 1'b0);
		directed_command(i2cm_pkg::CMD_START, 8'd0, 1'b0, 1'b1, i2cm_pkg::CMD_IDLE);
		directed_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b1, i2cm_pkg::CMD_IDLE);
		directed_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0, OP_SPARE);
		directed_command(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b1, i2cm_pkg::CMD_STOP);
		directed_command(i2cm_pkg::CMD_READ, 8'h00, 1'b0, 1'b1, i2cm_pkg::CMD_IDLE);
		directed_command(i2cm_pkg::CMD_READ, 8'hFF, 1'b1, 1'b0, i2cm_pkg::CMD_READ);
		directed_command(i2cm_pkg::CMD_SACK, 8'd0, 1'b0, 1'b1, i2cm_pkg::CMD_IDLE);
		directed_command(i2cm_pkg::CMD_SACK, 8'd0, 1'b1, 1'b0, i2cm_pkg::CMD_IDLE);
		directed_command(i2cm_pkg::CMD_RACK, 8'd0, 1'b0, 1'b0, i2cm_pkg::CMD_WRITE);
		directed_command(i2cm_pkg::CMD_RACK, 8'd0, 1'b1, 1'b1, i2cm_pkg::CMD_IDLE);
		directed_command(i2cm_pkg::CMD_STOP, 8'd0, 1'b0, 1'b1, i2cm_pkg::CMD_RACK);
		settle();

		for (ph = 0; ph < 8; ph++) begin
			mode = ph % 4;
			write_hold((mode == 3 && ph < 4) ? 16'd0 : 16'($urandom_range(3, 1)));
			tx_idle_pct = (mode == 1) ? 85 : (mode == 3) ? 21 : 0;
			rx_stall_pct = (mode == 2) ? 85 : (mode == 3) ? 21 : 0;
			target = pushed + 60;
			while (pushed < target) random_sequence();
			settle();
		end

		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[files.f]
rtl/i2cm_pkg.sv
rtl/i2cm_ifs.sv
rtl/i2cm_cfg.sv
rtl/i2cm_engine.sv
rtl/i2cm_out_reg.sv
rtl/i2c_master_bit_engine_core.sv
tb/tb_top.sv
